// ===== hdl/htlp_pkg.sv =====
// Shared types and constants for the linear probe hash table.
package htlp_pkg;

	localparam int TableSize = 1024;
	localparam int IdxW = $clog2(TableSize);
	localparam int CntW = IdxW + 1;
	localparam int ProbeW = IdxW + 2;
	localparam logic [31:0] MixMul = 32'h5bd1e995;
	localparam logic [7:0] ProbeBaseReset = 8'd10;

	typedef enum logic [1:0] {
		KIND_GET = 2'd0,
		KIND_PUT = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_NOP = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_H1,
		S_H2,
		S_H3,
		S_H4,
		S_H5,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

	// Constant part of the mix: seed and the all-zero upper word folded in.
	function automatic logic [31:0] hash_pre();
		logic [31:0] h;
		logic [31:0] hi;
		hi = 32'd0 * MixMul;
		hi = hi ^ (hi >> 24);
		hi = hi * MixMul;
		h = 32'd8 * MixMul;
		h = h ^ hi;
		h = h * MixMul;
		return h;
	endfunction

endpackage

// ===== hdl/hash_table_linear_probe_unit.sv =====
// Linear probe hash table: hash pipeline, probe sequencer and slot memories.
//
//  channel   | signals                                     | direction
//  request   | start, busy, kind, key, value               | in (busy out)
//  result    | done, result_value, status, claimed_slots   | out, one cycle
//  config    | cfg_we, cfg_wdata -> base_q                 | in
//
// A request passes the hash states (the accept in idle, then H1 to H4), then a
// read state and a compare and write back state per probed slot, then one result
// state; busy stays high until the result, so the next accept follows it. An
// unused kind or a zero key on put or remove skips the table. After reset a
// clearing pass writes zero to every slot while busy is high. The receiver cannot
// stall.
module hash_table_linear_probe_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [31:0] key,
	input  logic [31:0] value,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output logic        done,
	output logic [31:0] result_value,
	output logic [1:0]  status,
	output logic [10:0] claimed_slots
);

	localparam int IdxW = htlp_pkg::IdxW;

	logic [31:0] key_mem [htlp_pkg::TableSize];
	logic [31:0] val_mem [htlp_pkg::TableSize];

	htlp_pkg::state_t state_q, state_d;
	logic [7:0] base_q;
	logic [IdxW-1:0] idx_q, idx_d;
	logic [htlp_pkg::ProbeW-1:0] probe_q, probe_d;
	logic [htlp_pkg::CntW-1:0] count_q, count_d;
	logic [1:0] kind_q;
	logic [31:0] key_q, val_q, h_q, h_d;
	logic [31:0] rkey_q, rval_q;
	logic [31:0] res_q, res_d;
	logic [1:0] stat_q, stat_d;
	logic we;
	logic [31:0] wkey, wval;
	logic [htlp_pkg::ProbeW-1:0] limit, probe_inc;
	logic too_full;

	assign limit = htlp_pkg::ProbeW'(base_q) + htlp_pkg::ProbeW'(htlp_pkg::TableSize / 4);
	assign probe_inc = probe_q + 1'b1;
	assign too_full = ({3'd0, count_q} * (htlp_pkg::CntW + 3)'(5))
		> (htlp_pkg::CntW + 3)'(htlp_pkg::TableSize * 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htlp_pkg::S_CLEAR;
			base_q <= htlp_pkg::ProbeBaseReset;
			idx_q <= '0;
			probe_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) base_q <= cfg_wdata;
			idx_q <= idx_d;
			probe_q <= probe_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_q <= kind;
			key_q <= key;
			val_q <= (htlp_pkg::kind_t'(kind) == htlp_pkg::KIND_REMOVE) ? 32'd0 : value;
		end
		h_q <= h_d;
		res_q <= res_d;
		stat_q <= stat_d;
	end

	// Slot memories: one read and one write port each.
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[idx_q] <= wkey;
			val_mem[idx_q] <= wval;
		end
		rkey_q <= key_mem[idx_q];
		rval_q <= val_mem[idx_q];
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		probe_d = probe_q;
		count_d = count_q;
		h_d = h_q;
		res_d = res_q;
		stat_d = stat_q;
		we = 1'b0;
		wkey = rkey_q;
		wval = val_q;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			htlp_pkg::S_CLEAR: begin
				we = 1'b1;
				wkey = '0;
				wval = '0;
				idx_d = idx_q + 1'b1;
				if (idx_q == IdxW'(htlp_pkg::TableSize - 1)) state_d = htlp_pkg::S_IDLE;
			end
			htlp_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = htlp_pkg::S_H1;
					h_d = key * htlp_pkg::MixMul;
				end
			end
			htlp_pkg::S_H1: begin
				h_d = (h_q ^ (h_q >> 24)) * htlp_pkg::MixMul;
				state_d = htlp_pkg::S_H2;
			end
			htlp_pkg::S_H2: begin
				h_d = htlp_pkg::hash_pre() ^ h_q;
				h_d = h_d ^ (h_d >> 13);
				state_d = htlp_pkg::S_H3;
			end
			htlp_pkg::S_H3: begin
				h_d = h_q * htlp_pkg::MixMul;
				state_d = htlp_pkg::S_H4;
			end
			htlp_pkg::S_H4: begin
				h_d = h_q ^ (h_q >> 15);
				idx_d = h_d[IdxW-1:0];
				probe_d = '0;
				res_d = '0;
				stat_d = htlp_pkg::ST_OK;
				case (htlp_pkg::kind_t'(kind_q))
					htlp_pkg::KIND_GET: state_d = htlp_pkg::S_READ;
					htlp_pkg::KIND_PUT, htlp_pkg::KIND_REMOVE: begin
						if (key_q == '0) begin
							stat_d = htlp_pkg::ST_FULL;
							state_d = htlp_pkg::S_DONE;
						end else begin
							state_d = htlp_pkg::S_READ;
						end
					end
					default: state_d = htlp_pkg::S_DONE;
				endcase
			end
			htlp_pkg::S_READ: state_d = htlp_pkg::S_CHECK;
			htlp_pkg::S_CHECK: begin
				state_d = htlp_pkg::S_DONE;
				if (htlp_pkg::kind_t'(kind_q) == htlp_pkg::KIND_GET) begin
					if (rkey_q == '0) begin
						stat_d = htlp_pkg::ST_MISS;
					end else if (rkey_q == key_q) begin
						res_d = rval_q;
					end else begin
						probe_d = probe_inc;
						if (probe_inc > limit) stat_d = htlp_pkg::ST_FULL;
						else begin
							idx_d = idx_q + 1'b1;
							state_d = htlp_pkg::S_READ;
						end
					end
				end else begin
					if (rkey_q == '0) begin
						if (val_q != '0) begin
							we = 1'b1;
							wkey = key_q;
							count_d = count_q + 1'b1;
						end
					end else if (rkey_q == key_q) begin
						we = 1'b1;
						res_d = rval_q;
					end else begin
						probe_d = probe_inc;
						if (probe_inc >= limit || too_full) stat_d = htlp_pkg::ST_FULL;
						else begin
							idx_d = idx_q + 1'b1;
							state_d = htlp_pkg::S_READ;
						end
					end
				end
			end
			htlp_pkg::S_DONE: begin
				done = 1'b1;
				state_d = htlp_pkg::S_IDLE;
			end
			default: state_d = htlp_pkg::S_IDLE;
		endcase
	end

	assign result_value = res_q;
	assign status = stat_q;
	assign claimed_slots = 11'(count_q);

endmodule

// ===== hdl/htlp_checker.sv =====
// Port-level checks for the linear probe hash table.
module htlp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [31:0] result_value,
	input logic [10:0] claimed_slots
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result while idle");
	a_no_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("double result");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= htlp_pkg::ST_MISS) else $error("bad status");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != htlp_pkg::ST_OK) |-> result_value == 32'd0)
		else $error("fail with value");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> $stable(claimed_slots)) else $error("count moved early");

endmodule

bind hash_table_linear_probe_unit htlp_checker u_htlp_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .result_value(result_value), .claimed_slots(claimed_slots)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the linear probe hash table unit.
`timescale 1ns / 100ps

module testbench;

	localparam int StallLimit = 6000;
	localparam logic [31:0] Mul = 32'h5bd1e995;

	typedef enum logic [1:0] {ACT_REQ, ACT_CFG, ACT_DRAIN} act_t;

	typedef struct {
		act_t              act;
		htlp_pkg::kind_t   kind;
		logic [31:0]       key;
		logic [31:0]       value;
		logic [7:0]        base;
	} action_t;

	typedef struct {
		logic [31:0]       value;
		htlp_pkg::status_t status;
		logic [10:0]       claimed;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  kind = 2'd0;
	logic [31:0] key = 32'd0;
	logic [31:0] value = 32'd0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'd0;
	logic        done;
	logic [31:0] result_value;
	logic [1:0]  status;
	logic [10:0] claimed_slots;

	action_t     pending[$];
	answer_t     answers_due[$];
	logic [31:0] key_mem[htlp_pkg::TableSize];
	logic [31:0] val_mem[htlp_pkg::TableSize];
	int unsigned slots_used;
	logic [7:0]  probe_base;
	logic [31:0] key_pool[64];
	bit          took_item;
	int          gap_left;
	int          errors;
	int          stall_cycles;

	hash_table_linear_probe_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind), .key(key),
		.value(value), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
		.result_value(result_value), .status(status), .claimed_slots(claimed_slots)
	);

	always #6 clk = ~clk;

	function automatic logic [31:0] mix32(logic [31:0] k);
		k = k * Mul;
		k = k ^ (k >> 24);
		k = k * Mul;
		return k;
	endfunction

	function automatic int home_slot(logic [31:0] k);
		logic [31:0] h;
		h = 32'd8 * Mul;
		h = h ^ mix32(32'd0);
		h = h * Mul;
		h = h ^ mix32(k);
		h = h ^ (h >> 13);
		h = h * Mul;
		h = h ^ (h >> 15);
		return int'(h & (htlp_pkg::TableSize - 1));
	endfunction

	// Walk the probe chain and update the shadow table the way the block should.
	function automatic answer_t lookup_update(htlp_pkg::kind_t k, logic [31:0] kk,
		logic [31:0] v);
		answer_t a;
		int idx;
		int cnt;
		int lim;
		a.value = 32'd0;
		a.status = htlp_pkg::ST_OK;
		idx = home_slot(kk);
		cnt = 0;
		lim = int'(probe_base) + htlp_pkg::TableSize / 4;
		if (k == htlp_pkg::KIND_GET) begin
			forever begin
				if (key_mem[idx] == 32'd0) begin
					a.status = htlp_pkg::ST_MISS;
					break;
				end
				if (key_mem[idx] == kk) begin
					a.value = val_mem[idx];
					break;
				end
				cnt++;
				if (cnt > lim) begin
					a.status = htlp_pkg::ST_FULL;
					break;
				end
				idx = (idx + 1) % htlp_pkg::TableSize;
			end
		end else if (k != htlp_pkg::KIND_NOP) begin
			if (k == htlp_pkg::KIND_REMOVE) v = 32'd0;
			if (kk == 32'd0) a.status = htlp_pkg::ST_FULL;
			else forever begin
				if (key_mem[idx] == 32'd0) begin
					if (v != 32'd0) begin
						key_mem[idx] = kk;
						val_mem[idx] = v;
						slots_used++;
					end
					break;
				end
				if (key_mem[idx] == kk) begin
					a.value = val_mem[idx];
					val_mem[idx] = v;
					break;
				end
				cnt++;
				if (cnt >= lim || slots_used * 5 > htlp_pkg::TableSize * 4) begin
					a.status = htlp_pkg::ST_FULL;
					break;
				end
				idx = (idx + 1) % htlp_pkg::TableSize;
			end
		end
		a.claimed = slots_used[10:0];
		return a;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic add_req(htlp_pkg::kind_t k, logic [31:0] kk, logic [31:0] v);
		action_t a;
		a.act = ACT_REQ;
		a.kind = k;
		a.key = kk;
		a.value = v;
		a.base = 8'd0;
		pending.push_back(a);
	endtask

	task automatic add_ctl(act_t act, logic [7:0] b);
		action_t a;
		a.act = act;
		a.kind = htlp_pkg::KIND_NOP;
		a.key = 32'd0;
		a.value = 32'd0;
		a.base = b;
		pending.push_back(a);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic logic [31:0] rand_value();
		int r;
		r = $urandom_range(9);
		if (r == 0) return 32'd0;
		if (r == 1) return 32'hffffffff;
		return $urandom;
	endfunction

	// Accept transfers, update the predictor and check results.
	always @(posedge clk) begin
		answer_t a;
		if (arst_n) begin
			stall_cycles++;
			if (cfg_we) probe_base = cfg_wdata;
			if (done) begin
				stall_cycles = 0;
				if (answers_due.size() == 0) begin
					report("unexpected result", result_value, 32'd0);
				end else begin
					a = answers_due.pop_front();
					if (result_value !== a.value) report("result_value", result_value, a.value);
					if (status !== a.status)
						report("status", 32'(status), 32'(a.status));
					if (claimed_slots !== a.claimed)
						report("claimed_slots", 32'(claimed_slots), 32'(a.claimed));
				end
			end
			if (start && !busy) begin
				stall_cycles = 0;
				took_item = 1'b1;
				answers_due.push_back(lookup_update(htlp_pkg::kind_t'(kind), key, value));
			end
			if (stall_cycles >= StallLimit) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Drive the next queued action at the falling edge.
	always @(negedge clk) begin
		logic nxt_start;
		logic nxt_we;
		action_t a;
		nxt_start = start;
		nxt_we = 1'b0;
		if (arst_n) begin
			if (start && took_item) begin
				nxt_start = 1'b0;
				took_item = 1'b0;
				gap_left = pick_gap();
			end
			if (!nxt_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() > 0) begin
					a = pending[0];
					case (a.act)
						ACT_REQ: begin
							void'(pending.pop_front());
							kind <= a.kind;
							key <= a.key;
							value <= a.value;
							nxt_start = 1'b1;
						end
						ACT_CFG: begin
							// hold until the block is idle
							if (answers_due.size() == 0 && !busy) begin
								void'(pending.pop_front());
								cfg_wdata <= a.base;
								nxt_we = 1'b1;
							end
						end
						default: begin
							if (answers_due.size() == 0) void'(pending.pop_front());
						end
					endcase
				end
			end
		end
		start <= nxt_start;
		cfg_we <= nxt_we;
	end

	initial begin
		int n;
		int r;
		logic [31:0] kk;
		errors = 0;
		stall_cycles = 0;
		took_item = 1'b0;
		gap_left = 0;
		slots_used = 0;
		probe_base = htlp_pkg::ProbeBaseReset;
		for (int i = 0; i < htlp_pkg::TableSize; i++) begin
			key_mem[i] = 32'd0;
			val_mem[i] = 32'd0;
		end
		for (int i = 0; i < 64; i++) key_pool[i] = $urandom | 32'd1;

		// directed: misses, hits, updates, tombstones, zero keys, unused kind
		add_req(htlp_pkg::KIND_GET, 32'hffffffff, 32'd0);
		add_req(htlp_pkg::KIND_PUT, 32'hffffffff, 32'hffffffff);
		add_req(htlp_pkg::KIND_GET, 32'hffffffff, 32'd0);
		add_req(htlp_pkg::KIND_PUT, 32'hffffffff, 32'h12345678);
		add_req(htlp_pkg::KIND_REMOVE, 32'hffffffff, 32'h55555555);
		add_req(htlp_pkg::KIND_GET, 32'hffffffff, 32'd0);
		add_req(htlp_pkg::KIND_PUT, 32'd1, 32'd0);
		add_req(htlp_pkg::KIND_GET, 32'd1, 32'd0);
		add_req(htlp_pkg::KIND_REMOVE, 32'd2, 32'd7);
		add_req(htlp_pkg::KIND_PUT, 32'd1, 32'd1);
		add_req(htlp_pkg::KIND_PUT, 32'd0, 32'haaaaaaaa);
		add_req(htlp_pkg::KIND_REMOVE, 32'd0, 32'd0);
		add_req(htlp_pkg::KIND_GET, 32'd0, 32'd0);
		add_req(htlp_pkg::KIND_NOP, 32'h80000000, 32'h80000000);
		add_req(htlp_pkg::KIND_PUT, 32'hffffffff, 32'd3);
		add_req(htlp_pkg::KIND_GET, 32'd1, 32'd0);

		// random mix over a small key pool so hits and updates are common
		add_ctl(ACT_CFG, 8'($urandom_range(255)));
		for (int i = 0; i < 550; i++) begin
			if (i == 275) add_ctl(ACT_DRAIN, 8'd0);
			r = $urandom_range(99);
			if (r < 70) kk = key_pool[$urandom_range(63)];
			else if (r < 97) kk = $urandom;
			else kk = 32'd0;
			r = $urandom_range(99);
			add_req(r < 35 ? htlp_pkg::KIND_GET : r < 75 ? htlp_pkg::KIND_PUT :
				r < 95 ? htlp_pkg::KIND_REMOVE : htlp_pkg::KIND_NOP, kk, rand_value());
		end

		// long cluster around a few home slots drives the probe limit
		add_ctl(ACT_CFG, 8'd0);
		n = 0;
		while (n < 280) begin
			kk = $urandom;
			if (kk != 32'd0 && home_slot(kk) < 4) begin
				add_req(htlp_pkg::KIND_PUT, kk, rand_value() | 32'd1);
				if (n % 20 == 0) add_req(htlp_pkg::KIND_GET, kk ^ 32'h00010000, 32'd0);
				n++;
			end
		end
		add_req(htlp_pkg::KIND_GET, 32'h00000000, 32'd0);

		// fill past the load limit with the widest probe setting
		add_ctl(ACT_CFG, 8'd255);
		for (int i = 0; i < 520; i++) begin
			kk = $urandom | 32'd1;
			add_req(i % 8 == 7 ? htlp_pkg::KIND_GET : htlp_pkg::KIND_PUT, kk, rand_value());
		end
		add_ctl(ACT_CFG, 8'd10);
		for (int i = 0; i < 30; i++)
			add_req(htlp_pkg::kind_t'($urandom_range(2)), key_pool[$urandom_range(63)],
				rand_value());

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending.size() == 0 && !start && answers_due.size() == 0);
		repeat (30) @(posedge clk);
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/htlp_pkg.sv
hdl/hash_table_linear_probe_unit.sv
hdl/htlp_checker.sv
tb/sv/testbench.sv
